>>> hw/rtl/idq_pkg.sv
// idq_pkg: shared types and constants for the indexed deque with resize
// holds the word structs, opcodes, status codes and ring geometry
// no dependencies
package idq_pkg;

    // ring geometry (capacity is a power of two so slot math wraps naturally)
    localparam int CAPACITY = 64;
    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = AW + 1;

    // operation codes
    localparam logic [2:0] OP_APPEND     = 3'd0;
    localparam logic [2:0] OP_PREPEND    = 3'd1;
    localparam logic [2:0] OP_DROP_FRONT = 3'd2;
    localparam logic [2:0] OP_DROP_BACK  = 3'd3;
    localparam logic [2:0] OP_RESIZE     = 3'd4;
    localparam logic [2:0] OP_READ       = 3'd5;
    localparam logic [2:0] OP_WRITE      = 3'd6;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // input word
    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] value;
        logic [5:0]         position;
        logic [6:0]         new_size;
    } t_in_item;

    // result word
    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
    } t_out_item;

    // element store access for one operation
    typedef struct packed {
        logic               we;
        logic [AW-1:0]      waddr;
        logic signed [31:0] wdata;
        logic               re;
        logic [AW-1:0]      raddr;
    } t_mem_req;

    // per-item outcome handed to the result register
    typedef struct packed {
        logic       hit;
        logic [1:0] status;
    } t_op_res;

endpackage

>>> hw/rtl/idq_mem.sv
// idq_mem: element store of CAPACITY signed words
// one write port and one read port with registered read data; uses idq_pkg
module idq_mem (
    input  logic                     i_clk,
    input  idq_pkg::t_mem_req        i_req,
    output logic signed [31:0]       o_rdata
);
    import idq_pkg::*;

    logic signed [31:0] r_mem [CAPACITY];
    logic signed [31:0] r_q;

    // write and registered read; read register holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_q <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

>>> hw/rtl/idq_ctrl.sv
// idq_ctrl: front pointer, element count and slot valid bits of the ring
// decodes one word per fire, issues store access and status; uses idq_pkg
module idq_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  idq_pkg::t_in_item    i_item,
    output idq_pkg::t_mem_req    o_req,
    output idq_pkg::t_op_res     o_res
);
    import idq_pkg::*;

    logic [AW-1:0]       r_front, n_front;
    logic [CW-1:0]       r_count, n_count;
    logic [CAPACITY-1:0] r_valid, n_valid;

    logic                full, empty, pos_in, size_bad;
    logic [AW-1:0]       slot_back, slot_last, slot_pos, front_dec;
    logic [CAPACITY-1:0] drop_mask;
    logic [AW-1:0]       logical [CAPACITY];

    // slot arithmetic, wraps at the ring size
    assign full      = (r_count == CW'(CAPACITY));
    assign empty     = (r_count == '0);
    assign pos_in    = (CW'(i_item.position) < r_count);
    assign size_bad  = (i_item.new_size > CW'(CAPACITY));
    assign slot_back = r_front + r_count[AW-1:0];
    assign slot_last = slot_back - AW'(1);
    assign slot_pos  = r_front + AW'(i_item.position);
    assign front_dec = r_front - AW'(1);

    // slots whose logical index falls in [new_size, count) on shrink
    always_comb begin
        for (int j = 0; j < CAPACITY; j++) begin
            logical[j]   = AW'(j) - r_front;
            drop_mask[j] = (CW'(logical[j]) >= i_item.new_size) &&
                           (CW'(logical[j]) < r_count);
        end
    end

    // operation decode
    always_comb begin
        n_front    = r_front;
        n_count    = r_count;
        n_valid    = r_valid;
        o_req      = '0;
        o_req.wdata = i_item.value;
        o_res      = '0;
        o_res.status = ST_OK;
        case (i_item.opcode)
            OP_APPEND: begin
                if (full) begin
                    o_res.status = ST_FULL;
                end else begin
                    o_req.we           = i_fire;
                    o_req.waddr        = slot_back;
                    n_valid[slot_back] = 1'b1;
                    n_count            = r_count + CW'(1);
                end
            end
            OP_PREPEND: begin
                if (full) begin
                    o_res.status = ST_FULL;
                end else begin
                    o_req.we           = i_fire;
                    o_req.waddr        = front_dec;
                    n_valid[front_dec] = 1'b1;
                    n_front            = front_dec;
                    n_count            = r_count + CW'(1);
                end
            end
            OP_DROP_FRONT: begin
                if (empty) begin
                    o_res.status = ST_EMPTY;
                end else begin
                    n_valid[r_front] = 1'b0;
                    n_front          = r_front + AW'(1);
                    n_count          = r_count - CW'(1);
                end
            end
            OP_DROP_BACK: begin
                if (empty) begin
                    o_res.status = ST_EMPTY;
                end else begin
                    n_valid[slot_last] = 1'b0;
                    n_count            = r_count - CW'(1);
                end
            end
            OP_RESIZE: begin
                if (size_bad) begin
                    o_res.status = ST_RANGE;
                end else begin
                    n_valid = r_valid & ~drop_mask;
                    n_count = i_item.new_size;
                end
            end
            OP_READ: begin
                o_req.re    = i_fire;
                o_req.raddr = slot_pos;
                o_res.hit   = pos_in && r_valid[slot_pos];
            end
            OP_WRITE: begin
                if (!pos_in) begin
                    o_res.status = ST_RANGE;
                end else begin
                    o_req.we          = i_fire;
                    o_req.waddr       = slot_pos;
                    n_valid[slot_pos] = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // ring state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_valid <= '0;
        end else if (i_fire) begin
            r_front <= n_front;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

endmodule

>>> hw/rtl/indexed_deque_with_resize.sv
// indexed_deque_with_resize: top level of the indexed ring deque
// input register, ring control, element store and result register; uses idq_pkg
//
// Usage:
//  - input channel i_in_valid / o_in_ready carries one operation word:
//    push back, push front, pop front, pop back, resize, read or write
//  - output channel o_out_valid / i_out_ready returns exactly one result word
//    per operation, in order: read value (zero unless a live, set element was
//    read) and status (ok, empty, full, out of range)
//  - an accepted word passes the input register, then decode into the result
//    register and the registered store read port, before its result is valid
//  - throughput is one word per cycle unless the receiver stalls; the ring
//    state updates once per word and the store sees at most one write or one
//    read per word
//  - when the receiver stalls, the result register and store read data hold,
//    the input register fills, and o_in_ready drops only once both are full
//  - synchronous reset empties the deque: front pointer and count go to zero
//    and all slot valid bits clear together; no clearing pass is needed
module indexed_deque_with_resize (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  idq_pkg::t_in_item     i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output idq_pkg::t_out_item    o_out_item
);
    import idq_pkg::*;

    logic               r_in_valid;
    t_in_item           r_in_item;
    logic               r_out_valid;
    t_op_res            r_out_res;
    logic               s1_fire;
    t_mem_req           mem_req;
    t_op_res            op_res;
    logic signed [31:0] mem_rdata;

    // stage handshakes
    assign s1_fire    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || s1_fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // ring control
    idq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (s1_fire),
        .i_item  (r_in_item),
        .o_req   (mem_req),
        .o_res   (op_res)
    );

    // element store
    idq_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid <= s1_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_res <= op_res;
        end
    end

    // result word
    assign o_out_valid           = r_out_valid;
    assign o_out_item.read_value = r_out_res.hit ? mem_rdata : 32'sd0;
    assign o_out_item.status     = r_out_res.status;

    // a decoded word always lands in the result register
    a_fire_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> o_out_valid)
        else $error("decoded word did not reach result register");

    // one store access per word
    a_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_req.we && mem_req.re))
        else $error("store written and read by the same word");

    // a failed operation never returns data
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status != ST_OK)) |-> (o_out_item.read_value == 32'sd0))
        else $error("nonzero read value with error status");

    // a read hit always comes from a read operation's store access
    a_hit_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && op_res.hit) |-> mem_req.re)
        else $error("read hit without store read");

endmodule

>>> tb/idq_result_checker.sv
`timescale 1ns / 100ps
// idq_result_checker: watches both word channels of the indexed deque, predicts
// each result from its own ring model and compares it field by field; uses idq_pkg
module idq_result_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  idq_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  idq_pkg::t_out_item i_out_item,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked,
    output logic [6:0]         o_depth
);
    import idq_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // predicted ring state
    logic signed [31:0] ring_word [CAPACITY];
    logic               ring_set  [CAPACITY];
    logic [AW-1:0]      head_slot;
    logic [CW-1:0]      live_count;

    // results owed by the block, oldest first
    t_out_item          predicted_replies [$];

    assign o_depth = live_count;

    // apply one operation to the ring model and return the reply it gives
    function automatic t_out_item apply_deque_op(input t_in_item w);
        t_out_item     reply;
        logic [AW-1:0] slot;
        reply.read_value = '0;
        reply.status     = ST_OK;
        case (w.opcode)
            OP_APPEND: begin
                if (live_count == CW'(CAPACITY)) begin
                    reply.status = ST_FULL;
                end else begin
                    slot            = head_slot + live_count[AW-1:0];
                    ring_word[slot] = w.value;
                    ring_set[slot]  = 1'b1;
                    live_count      = live_count + CW'(1);
                end
            end
            OP_PREPEND: begin
                if (live_count == CW'(CAPACITY)) begin
                    reply.status = ST_FULL;
                end else begin
                    head_slot            = head_slot - AW'(1);
                    ring_word[head_slot] = w.value;
                    ring_set[head_slot]  = 1'b1;
                    live_count           = live_count + CW'(1);
                end
            end
            OP_DROP_FRONT: begin
                if (live_count == '0) begin
                    reply.status = ST_EMPTY;
                end else begin
                    ring_set[head_slot] = 1'b0;
                    head_slot           = head_slot + AW'(1);
                    live_count          = live_count - CW'(1);
                end
            end
            OP_DROP_BACK: begin
                if (live_count == '0) begin
                    reply.status = ST_EMPTY;
                end else begin
                    live_count     = live_count - CW'(1);
                    slot           = head_slot + live_count[AW-1:0];
                    ring_set[slot] = 1'b0;
                end
            end
            OP_RESIZE: begin
                if (w.new_size > CW'(CAPACITY)) begin
                    reply.status = ST_RANGE;
                end else begin
                    // slots that fall off the end lose their valid bit
                    for (int i = int'(w.new_size); i < int'(live_count); i++) begin
                        slot           = head_slot + AW'(i);
                        ring_set[slot] = 1'b0;
                    end
                    live_count = w.new_size;
                end
            end
            OP_READ: begin
                if (CW'(w.position) < live_count) begin
                    slot = head_slot + w.position;
                    if (ring_set[slot]) begin
                        reply.read_value = ring_word[slot];
                    end
                end
            end
            OP_WRITE: begin
                if (CW'(w.position) >= live_count) begin
                    reply.status = ST_RANGE;
                end else begin
                    slot            = head_slot + w.position;
                    ring_word[slot] = w.value;
                    ring_set[slot]  = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return reply;
    endfunction

    // sample both channels at the rising edge
    always @(posedge i_clk) begin : watch_channels
        t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < CAPACITY; i++) begin
                ring_word[i] = '0;
                ring_set[i]  = 1'b0;
            end
            head_slot  = '0;
            live_count = '0;
            predicted_replies.delete();
            o_pending  = 0;
        end else begin
            // result word leaving the block
            if (i_out_valid && i_out_ready) begin
                if (predicted_replies.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_LIMIT) begin
                        $display("unexpected result word: read_value %0d status %0d",
                                 i_out_item.read_value, i_out_item.status);
                    end
                end else begin
                    want = predicted_replies[0];
                    predicted_replies.delete(0);
                    o_checked++;
                    if (i_out_item.read_value !== want.read_value ||
                        i_out_item.status !== want.status) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_LIMIT) begin
                            $display("result %0d: read_value exp %0d got %0d,",
                                     o_checked, want.read_value, i_out_item.read_value,
                                     " status exp %0d got %0d",
                                     want.status, i_out_item.status);
                        end
                    end
                end
            end
            // operation word entering the block
            if (i_in_valid && i_in_ready) begin
                predicted_replies.insert(predicted_replies.size(),
                                         apply_deque_op(i_in_item));
            end
            o_pending = predicted_replies.size();
        end
    end

endmodule

>>> tb/indexed_deque_with_resize_tb.sv
`timescale 1ns / 100ps
// indexed_deque_with_resize_tb: directed and random operation words with random
// gaps and stalls on both channels; uses idq_pkg, the block and idq_result_checker
module indexed_deque_with_resize_tb;
    import idq_pkg::*;

    localparam logic [2:0] OP_UNUSED     = 3'd7;
    localparam int         RANDOM_BLOCKS = 15;
    localparam int         BLOCK_LEN     = 50;
    localparam int         MAX_WAIT      = 15;
    localparam int         DRAIN_CYCLES  = 20;
    localparam int         CYCLE_LIMIT   = 200000;

    // how a stretch of random words is weighted
    typedef enum int {
        MIX_DIRECTED,
        MIX_GROW,
        MIX_SHRINK,
        MIX_BALANCED,
        MIX_NOISE
    } t_mix;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;

    int         fail_count;
    int         pending;
    int         checked;
    logic [6:0] depth;
    int         cycles;
    int         op_seen [8];
    bit         quiet_tx;
    bit         quiet_rx;

    indexed_deque_with_resize dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    idq_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_depth      (depth)
    );

    // 4 ns clock
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // cycle limit
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("run stopped after %0d cycles, %0d results outstanding", cycles, pending);
        $display("[indexed_deque_with_resize] ERROR");
        $finish;
    end

    // receiver: stall for a random wait before taking each result word
    initial begin : result_sink
        int stall;
        out_ready = 1'b0;
        forever begin
            stall = quiet_rx ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    function automatic t_in_item make_word(input logic [2:0] op, input logic signed [31:0] val,
                                           input int pos, input int size);
        t_in_item w;
        w.opcode   = op;
        w.value    = val;
        w.position = 6'(pos);
        w.new_size = 7'(size);
        return w;
    endfunction

    // random word; positions and sizes are aimed near the current length
    function automatic t_in_item random_word(input t_mix mix);
        t_in_item w;
        int       r;
        int       lo;
        int       hi;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_GROW: begin
                if (r < 35)      w.opcode = OP_APPEND;
                else if (r < 65) w.opcode = OP_PREPEND;
                else if (r < 80) w.opcode = OP_READ;
                else if (r < 92) w.opcode = OP_WRITE;
                else if (r < 96) w.opcode = OP_DROP_FRONT;
                else if (r < 99) w.opcode = OP_DROP_BACK;
                else             w.opcode = OP_RESIZE;
            end
            MIX_SHRINK: begin
                if (r < 30)      w.opcode = OP_DROP_FRONT;
                else if (r < 60) w.opcode = OP_DROP_BACK;
                else if (r < 75) w.opcode = OP_READ;
                else if (r < 85) w.opcode = OP_WRITE;
                else if (r < 92) w.opcode = OP_APPEND;
                else if (r < 97) w.opcode = OP_PREPEND;
                else             w.opcode = OP_RESIZE;
            end
            MIX_BALANCED: begin
                if (r < 15)      w.opcode = OP_APPEND;
                else if (r < 30) w.opcode = OP_PREPEND;
                else if (r < 42) w.opcode = OP_DROP_FRONT;
                else if (r < 54) w.opcode = OP_DROP_BACK;
                else if (r < 72) w.opcode = OP_READ;
                else if (r < 90) w.opcode = OP_WRITE;
                else if (r < 97) w.opcode = OP_RESIZE;
                else             w.opcode = OP_UNUSED;
            end
            default: begin
                w.opcode = 3'($urandom_range(0, 7));
            end
        endcase

        // value: mostly random, sometimes the extremes and zero
        r = $urandom_range(0, 19);
        if (r == 0)      w.value = 32'sh7FFF_FFFF;
        else if (r == 1) w.value = 32'sh8000_0000;
        else if (r == 2) w.value = '0;
        else             w.value = $urandom;

        // position: mostly inside the live range
        if (mix == MIX_NOISE || depth == '0 || $urandom_range(0, 6) == 0) begin
            w.position = 6'($urandom_range(0, 63));
        end else begin
            w.position = 6'($urandom_range(0, int'(depth) - 1));
        end

        // new size: mostly near the current length, sometimes the ends or too large
        r = $urandom_range(0, 9);
        if (mix == MIX_NOISE || r == 0) begin
            w.new_size = 7'($urandom_range(0, 127));
        end else if (r == 1) begin
            w.new_size = ($urandom_range(0, 1) != 0) ? 7'(CAPACITY) : 7'd0;
        end else begin
            lo = (int'(depth) > 8) ? int'(depth) - 8 : 0;
            hi = (int'(depth) + 8 < CAPACITY) ? int'(depth) + 8 : CAPACITY;
            w.new_size = 7'($urandom_range(lo, hi));
        end
        return w;
    endfunction

    // send one word after a random gap; random words are built once the gap is over
    task automatic issue_word(input t_mix mix, input t_in_item fixed);
        int       gap;
        t_in_item w;
        gap = quiet_tx ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        w = (mix == MIX_DIRECTED) ? fixed : random_word(mix);
        in_item  <= w;
        in_valid <= 1'b1;
        op_seen[w.opcode]++;
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    // reset, stimulus and verdict
    initial begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
        foreach (op_seen[i]) op_seen[i] = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty deque, pushes at both ends, extremes, full and range cases
        issue_word(MIX_DIRECTED, make_word(OP_DROP_FRONT, 0, 0, 0));
        issue_word(MIX_DIRECTED, make_word(OP_DROP_BACK, 0, 0, 0));
        issue_word(MIX_DIRECTED, make_word(OP_READ, 0, 0, 0));
        issue_word(MIX_DIRECTED, make_word(OP_WRITE, 5, 0, 0));
        issue_word(MIX_DIRECTED, make_word(OP_APPEND, 32'sh7FFF_FFFF, 0, 0));
        issue_word(MIX_DIRECTED, make_word(OP_PREPEND, 32'sh8000_0000, 0, 0));
        issue_word(MIX_DIRECTED, make_word(OP_APPEND, 0, 0, 0));
        issue_word(MIX_DIRECTED, make_word(OP_APPEND, -1, 0, 0));
        issue_word(MIX_DIRECTED, make_word(OP_READ, 0, 0, 0));
        issue_word(MIX_DIRECTED, make_word(OP_READ, 0, 3, 0));
        // a stored zero reads back as zero
        issue_word(MIX_DIRECTED, make_word(OP_WRITE, 0, 1, 0));
        issue_word(MIX_DIRECTED, make_word(OP_READ, 0, 1, 0));
        // write and read past the end
        issue_word(MIX_DIRECTED, make_word(OP_WRITE, 1, 63, 0));
        issue_word(MIX_DIRECTED, make_word(OP_READ, 0, 63, 0));
        issue_word(MIX_DIRECTED, make_word(OP_DROP_FRONT, 0, 0, 0));
        issue_word(MIX_DIRECTED, make_word(OP_DROP_BACK, 0, 0, 0));
        // shrink drops slots, growth to capacity exposes zeros, then pushes overflow
        issue_word(MIX_DIRECTED, make_word(OP_RESIZE, 0, 0, 1));
        issue_word(MIX_DIRECTED, make_word(OP_RESIZE, 0, 0, CAPACITY));
        issue_word(MIX_DIRECTED, make_word(OP_READ, 0, 63, 0));
        issue_word(MIX_DIRECTED, make_word(OP_READ, 0, 1, 0));
        issue_word(MIX_DIRECTED, make_word(OP_APPEND, 9, 0, 0));
        issue_word(MIX_DIRECTED, make_word(OP_PREPEND, 9, 0, 0));
        issue_word(MIX_DIRECTED, make_word(OP_RESIZE, 0, 0, 127));
        issue_word(MIX_DIRECTED, make_word(OP_UNUSED, -1, 63, 127));
        issue_word(MIX_DIRECTED, make_word(OP_RESIZE, 0, 0, 0));

        // random stretches, each with its own weighting and idling
        for (int b = 0; b < RANDOM_BLOCKS; b++) begin : random_stretch
            t_mix mix;
            mix      = t_mix'($urandom_range(1, 4));
            quiet_tx = ($urandom_range(0, 3) == 0);
            quiet_rx = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < BLOCK_LEN; n++) begin
                issue_word(mix, '0);
            end
        end

        // drain
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d push back, %0d push front, %0d pop front, %0d pop back words",
                 op_seen[OP_APPEND], op_seen[OP_PREPEND], op_seen[OP_DROP_FRONT],
                 op_seen[OP_DROP_BACK]);
        $display("plus %0d resize, %0d read, %0d write, %0d unused; %0d results compared",
                 op_seen[OP_RESIZE], op_seen[OP_READ], op_seen[OP_WRITE], op_seen[OP_UNUSED],
                 checked);
        if (fail_count == 0) begin
            $display("[indexed_deque_with_resize] OK");
        end else begin
            $display("[indexed_deque_with_resize] ERROR");
        end
        $finish;
    end

endmodule
